### hdl/assert_macros.svh
// assertion helpers included by the executor top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/tpie_pkg.sv
// ----------------------------------------------------------------------------
// tpie_pkg
// Constants, opcode codes and the shared result type of the pointer machine executor.
// ----------------------------------------------------------------------------
`default_nettype none

package tpie_pkg;

   localparam int NUM_REGS   = 10;
   localparam int DATA_WIDTH = 32;
   localparam int PC_WIDTH   = 16;
   localparam int CP_WIDTH   = $clog2(NUM_REGS);
   localparam int LEN_WIDTH  = 16;
   localparam int CMP_WIDTH  = (PC_WIDTH > LEN_WIDTH) ? PC_WIDTH : LEN_WIDTH;

   localparam logic [3:0] OP_PTR_DOWN     = 4'd0;
   localparam logic [3:0] OP_PTR_UP       = 4'd1;
   localparam logic [3:0] OP_INC          = 4'd2;
   localparam logic [3:0] OP_DEC          = 4'd3;
   localparam logic [3:0] OP_ADD_ACC      = 4'd4;
   localparam logic [3:0] OP_SUB_ACC      = 4'd5;
   localparam logic [3:0] OP_OUTPUT       = 4'd6;
   localparam logic [3:0] OP_INPUT        = 4'd7;
   localparam logic [3:0] OP_LOAD_ACC     = 4'd8;
   localparam logic [3:0] OP_STORE_ACC    = 4'd9;
   localparam logic [3:0] OP_OR           = 4'd10;
   localparam logic [3:0] OP_AND          = 4'd11;
   localparam logic [3:0] OP_EQ           = 4'd12;
   localparam logic [3:0] OP_LOOP_START   = 4'd13;
   localparam logic [3:0] OP_LOOP_END     = 4'd14;
   localparam logic [3:0] OP_LOOP_RESTART = 4'd15;

   typedef struct packed {
      logic                  out_valid;
      logic [31:0]           out_value;
      logic [15:0]           next_pc;
      logic                  was_skipped;
      logic                  done_res;
   } result_type;

endpackage

`default_nettype wire

### hdl/tiny_pointer_isa_executor.sv
// ----------------------------------------------------------------------------
// tiny_pointer_isa_executor
// Ten-register pointer machine executing one 4-bit opcode per item.
// ----------------------------------------------------------------------------
// Each accepted item is one opcode plus an input value; each yields exactly
// one result with the next pc to fetch, an output flag and value, a skip flag
// and a done flag. Throughput is one item per clock while rsp_stall is low.
// An item goes from the input register, through execute, into the result
// register. The rate is set by the machine state loop: an instruction
// reads and updates the register file, pointer, pc and loop state at once.
// The user writes program_length through csr_wr_en/csr_wr_data only while
// idle; the block itself does not enforce this.
`default_nettype none

module tiny_pointer_isa_executor
   import tpie_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_opcode,
   input  wire logic signed [31:0] req_input_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_out_valid,
   output logic signed [31:0]      rsp_out_value,
   output logic [15:0]             rsp_next_pc,
   output logic                    rsp_was_skipped,
   output logic                    rsp_done_res,
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data
);

`include "assert_macros.svh"

   logic                  in_valid_ff;
   logic [3:0]            opcode_ff;
   logic signed [31:0]    input_value_ff;
   logic [LEN_WIDTH-1:0]  length_ff;
   logic                  rsp_valid_ff;
   result_type            result_ff;
   result_type            result;
   logic                  exec_en;

   // execute when the result register is free or being emptied
   assign exec_en   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !exec_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         length_ff    <= LEN_WIDTH'(1);
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         if (exec_en)               rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)       rsp_valid_ff <= 1'b0;
         if (csr_wr_en) length_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         opcode_ff      <= req_opcode;
         input_value_ff <= req_input_value;
      end
      if (exec_en) result_ff <= result;
   end

   tpie_core u_core (
      .clock          (clock),
      .reset          (reset),
      .exec_en        (exec_en),
      .opcode         (opcode_ff),
      .input_value    (input_value_ff),
      .program_length (length_ff),
      .result         (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_valid   = result_ff.out_valid;
   assign rsp_out_value   = result_ff.out_value;
   assign rsp_next_pc     = result_ff.next_pc;
   assign rsp_was_skipped = result_ff.was_skipped;
   assign rsp_done_res    = result_ff.done_res;

   `ASSERT_NOW(a_skip_no_output, clock, reset, rsp_valid && rsp_was_skipped, !rsp_out_valid)
   `ASSERT_NOW(a_value_zero, clock, reset, rsp_valid && !rsp_out_valid, rsp_out_value == 32'sd0)
   `ASSERT_NEXT(a_exec_fills_rsp, clock, reset, exec_en, rsp_valid_ff)
   `ASSERT_NEXT(a_held_item_kept, clock, reset, in_valid_ff && !exec_en, in_valid_ff)

endmodule

`default_nettype wire

### hdl/tpie_core.sv
// ----------------------------------------------------------------------------
// tpie_core
// Machine state and combinational instruction execute logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tpie_core
   import tpie_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  exec_en,
   input  wire logic [3:0]            opcode,
   input  wire logic signed [31:0]    input_value,
   input  wire logic [LEN_WIDTH-1:0]  program_length,
   output result_type                 result
);

   logic [DATA_WIDTH-1:0] reg_file_ff [NUM_REGS];
   logic [DATA_WIDTH-1:0] reg_file_in [NUM_REGS];
   logic [CP_WIDTH-1:0]   cp_ff, cp_in;
   logic [PC_WIDTH-1:0]   pc_ff, pc_in;
   logic [PC_WIDTH-1:0]   loop_ff, loop_in;
   logic                  skip_ff, skip_in;

   logic [DATA_WIDTH-1:0] acc;
   logic [DATA_WIDTH-1:0] cell_val;
   logic                  skipped;
   logic                  out_valid;
   logic [31:0]           out_value;

   always_comb begin
      acc         = reg_file_ff[0];
      cell_val    = reg_file_ff[cp_ff];
      reg_file_in = reg_file_ff;
      cp_in       = cp_ff;
      pc_in       = pc_ff + PC_WIDTH'(1);
      loop_in     = loop_ff;
      skip_in     = skip_ff;
      out_valid   = 1'b0;
      out_value   = '0;
      // while skipping, only a loop end is executed
      skipped     = skip_ff && (opcode != OP_LOOP_END);
      if (!skipped) begin
         unique case (opcode)
            OP_PTR_DOWN: begin
               if (cp_ff > CP_WIDTH'(1)) cp_in = cp_ff - CP_WIDTH'(1);
            end
            OP_PTR_UP: begin
               if (cp_ff < CP_WIDTH'(NUM_REGS - 1)) cp_in = cp_ff + CP_WIDTH'(1);
            end
            OP_INC:       reg_file_in[cp_ff] = cell_val + DATA_WIDTH'(1);
            OP_DEC:       reg_file_in[cp_ff] = cell_val - DATA_WIDTH'(1);
            OP_ADD_ACC:   reg_file_in[cp_ff] = cell_val + acc;
            OP_SUB_ACC:   reg_file_in[cp_ff] = cell_val - acc;
            OP_OUTPUT: begin
               out_valid = 1'b1;
               out_value = 32'(signed'(cell_val));
            end
            OP_INPUT:     reg_file_in[cp_ff] = DATA_WIDTH'(input_value);
            OP_LOAD_ACC:  reg_file_in[0] = cell_val;
            OP_STORE_ACC: reg_file_in[cp_ff] = acc;
            OP_OR:        reg_file_in[0] = DATA_WIDTH'((acc != '0) || (cell_val != '0));
            OP_AND:       reg_file_in[0] = DATA_WIDTH'((acc != '0) && (cell_val != '0));
            OP_EQ:        reg_file_in[0] = DATA_WIDTH'(acc == cell_val);
            OP_LOOP_START: begin
               if (acc == '0) skip_in = 1'b1;
               else           loop_in = pc_ff;
            end
            OP_LOOP_END: begin
               if (skip_ff) skip_in = 1'b0;
               else         pc_in   = loop_ff;
            end
            // loop restart
            default:      pc_in = loop_ff;
         endcase
      end
      result.out_valid   = out_valid;
      result.out_value   = out_value;
      result.next_pc     = 16'(pc_in);
      result.was_skipped = skipped;
      result.done_res    = CMP_WIDTH'(pc_in) >= CMP_WIDTH'(program_length);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) reg_file_ff[i] <= '0;
         cp_ff   <= CP_WIDTH'(1);
         pc_ff   <= '0;
         loop_ff <= '0;
         skip_ff <= 1'b0;
      end else if (exec_en) begin
         reg_file_ff <= reg_file_in;
         cp_ff       <= cp_in;
         pc_ff       <= pc_in;
         loop_ff     <= loop_in;
         skip_ff     <= skip_in;
      end
   end

endmodule

`default_nettype wire

### tb/tiny_pointer_isa_executor_tb.sv
// ----------------------------------------------------------------------------
// tiny_pointer_isa_executor_tb
// Self-checking bench for the pointer machine executor. A behavioral copy of
// the machine predicts every result; results are matched in order, field by
// field. Directed opcode, pointer-bound and zero-length tests come first, then
// random loop-shaped programs under several idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tiny_pointer_isa_executor_tb;
   import tpie_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_opcode;
   logic signed [31:0] req_input_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_out_valid;
   logic signed [31:0] rsp_out_value;
   logic [15:0]        rsp_next_pc;
   logic               rsp_was_skipped;
   logic               rsp_done_res;
   logic               csr_wr_en;
   logic [15:0]        csr_wr_data;

   tiny_pointer_isa_executor u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_input_value (req_input_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_value   (rsp_out_value),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_was_skipped (rsp_was_skipped),
      .rsp_done_res    (rsp_done_res),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // machine state as the bench sees it
   logic [DATA_WIDTH-1:0] cells [NUM_REGS];
   logic [CP_WIDTH-1:0]   pointer;
   logic [PC_WIDTH-1:0]   pc;
   logic [PC_WIDTH-1:0]   loop_pc;
   logic                  skipping;
   logic [LEN_WIDTH-1:0]  program_len;

   result_type pending_results[$];
   int         error_count;
   int         cycle_count;
   int         gap_pct;
   int         stall_pct;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic result_type execute_instruction(input logic [3:0] op,
                                                      input logic [31:0] value);
      result_type          res;
      logic [31:0]         acc;
      logic [31:0]         cell_val;
      logic [PC_WIDTH-1:0] next;
      int                  cp;
      res = '0;
      cp = int'(pointer);
      if (cp < 1 || cp > NUM_REGS - 1) begin
         cp = 1;
      end
      acc      = cells[0];
      cell_val = cells[cp];
      next = pc + 1'b1;
      if (skipping && op != OP_LOOP_END) begin
         res.was_skipped = 1'b1;
      end else begin
         case (op)
            OP_PTR_DOWN:     if (cp > 1) cp--;
            OP_PTR_UP:       if (cp < NUM_REGS - 1) cp++;
            OP_INC:          cells[cp] = cell_val + 1;
            OP_DEC:          cells[cp] = cell_val - 1;
            OP_ADD_ACC:      cells[cp] = cell_val + acc;
            OP_SUB_ACC:      cells[cp] = cell_val - acc;
            OP_OUTPUT: begin
               res.out_valid = 1'b1;
               res.out_value = cell_val;
            end
            OP_INPUT:        cells[cp] = value;
            OP_LOAD_ACC:     cells[0] = cell_val;
            OP_STORE_ACC:    cells[cp] = acc;
            OP_OR:           cells[0] = (acc != 0 || cell_val != 0) ? 1 : 0;
            OP_AND:          cells[0] = (acc != 0 && cell_val != 0) ? 1 : 0;
            OP_EQ:           cells[0] = (acc == cell_val) ? 1 : 0;
            OP_LOOP_START: begin
               if (acc == 0) begin
                  skipping = 1'b1;
               end else begin
                  loop_pc = pc;
               end
            end
            OP_LOOP_END: begin
               if (skipping) begin
                  skipping = 1'b0;
               end else begin
                  next = loop_pc;
               end
            end
            OP_LOOP_RESTART: next = loop_pc;
         endcase
      end
      pointer = CP_WIDTH'(cp);
      pc = next;
      res.next_pc  = next;
      res.done_res = (next >= program_len);
      return res;
   endfunction

   // prediction, checking and register mirror, all at the rising edge
   always @(posedge clock) begin
      result_type exp_res;
      if (reset) begin
         foreach (cells[i]) cells[i] = '0;
         pointer     = 1;
         pc          = '0;
         loop_pc     = '0;
         skipping    = 1'b0;
         program_len = 1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result with no item outstanding: next_pc %0d", rsp_next_pc);
               error_count++;
            end else begin
               exp_res = pending_results.pop_front();
               if (rsp_out_valid !== exp_res.out_valid) begin
                  $error("out_valid: expected %0d, actual %0d",
                         exp_res.out_valid, rsp_out_valid);
                  error_count++;
               end
               if (rsp_out_value !== exp_res.out_value) begin
                  $error("out_value: expected %h, actual %h",
                         exp_res.out_value, rsp_out_value);
                  error_count++;
               end
               if (rsp_next_pc !== exp_res.next_pc) begin
                  $error("next_pc: expected %0d, actual %0d",
                         exp_res.next_pc, rsp_next_pc);
                  error_count++;
               end
               if (rsp_was_skipped !== exp_res.was_skipped) begin
                  $error("was_skipped: expected %0d, actual %0d",
                         exp_res.was_skipped, rsp_was_skipped);
                  error_count++;
               end
               if (rsp_done_res !== exp_res.done_res) begin
                  $error("done_res: expected %0d, actual %0d",
                         exp_res.done_res, rsp_done_res);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(execute_instruction(req_opcode, req_input_value));
         end
         if (csr_wr_en) begin
            program_len = csr_wr_data;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tiny_pointer_isa_executor_tb NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   task automatic send_item(input logic [3:0] op, input logic [31:0] value);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_input_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // hold the sender off until every outstanding result has come back
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_program_length(input logic [15:0] len);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [31:0] random_word;
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'hffff_ffff;
         3:       return 32'h7fff_ffff;
         4:       return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_all_opcodes;
      write_program_length(16'd12);
      gap_pct   = 12;
      stall_pct = 12;
      send_item(OP_PTR_DOWN, 32'h0);            // already at the lowest cell
      send_item(OP_INPUT, 32'h7fff_ffff);
      send_item(OP_INC, 32'h0);                 // wraps to the most negative
      send_item(OP_OUTPUT, 32'h0);
      send_item(OP_LOAD_ACC, 32'h0);
      send_item(OP_PTR_UP, 32'h0);
      send_item(OP_INPUT, 32'hffff_ffff);
      send_item(OP_SUB_ACC, 32'h0);
      send_item(OP_ADD_ACC, 32'h0);
      send_item(OP_DEC, 32'h0);
      send_item(OP_STORE_ACC, 32'h0);
      send_item(OP_EQ, 32'h0);
      send_item(OP_OR, 32'h0);
      send_item(OP_AND, 32'h0);
      send_item(OP_LOOP_START, 32'h0);          // acc nonzero, records the pc
      send_item(OP_OUTPUT, 32'h0);
      send_item(OP_LOOP_END, 32'h0);
      send_item(OP_LOOP_RESTART, 32'h0);
      send_item(OP_INPUT, 32'h0);
      send_item(OP_LOAD_ACC, 32'h0);
      send_item(OP_LOOP_START, 32'h0);          // acc zero, starts skipping
      send_item(OP_INC, 32'h0);
      send_item(OP_LOOP_RESTART, 32'h0);
      send_item(OP_LOOP_END, 32'h0);            // only clears the skip
   endtask

   task automatic test_pointer_bounds;
      write_program_length(16'd1);
      gap_pct   = 0;
      stall_pct = 0;
      repeat (NUM_REGS) send_item(OP_PTR_UP, 32'h0);
      send_item(OP_INPUT, 32'ha5a5_5a5a);
      send_item(OP_OUTPUT, 32'h0);
   endtask

   task automatic test_zero_length;
      write_program_length(16'd0);
      send_item(OP_PTR_DOWN, 32'h0);
      send_item(OP_LOOP_RESTART, 32'h0);
      send_item(OP_OUTPUT, 32'h0);
   endtask

   task automatic send_loop_block(output int n);
      int body;
      n = 0;
      if ($urandom_range(1)) begin
         send_item(OP_INPUT, ($urandom_range(3) == 0) ? 32'h0 : random_word());
         send_item(OP_LOAD_ACC, random_word());
         n += 2;
      end
      send_item(OP_LOOP_START, random_word());
      n++;
      body = $urandom_range(1, 6);
      repeat (body) begin
         if ($urandom_range(19) == 0) begin
            send_item(OP_LOOP_RESTART, random_word());
         end else begin
            send_item(4'($urandom_range(int'(OP_EQ))), random_word());
         end
         n++;
      end
      send_item(OP_LOOP_END, random_word());
      n++;
   endtask

   task automatic run_random_phase(input int gap, input int stall, input int count);
      int sent;
      int block;
      if ($urandom_range(3) == 0) begin
         write_program_length(16'($urandom()));
      end else begin
         write_program_length(pc + 16'($urandom_range(40)));
      end
      gap_pct   = gap;
      stall_pct = stall;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 7) begin
            send_loop_block(block);
            sent += block;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_item(4'($urandom_range(int'(OP_LOOP_RESTART))), random_word());
               sent++;
            end
         end
         if (sent >= count / 2 && sent < count / 2 + 11) begin
            drain();
         end
      end
   endtask

   task automatic test_random_programs;
      run_random_phase(0, 0, 115);
      run_random_phase(46, 0, 115);
      run_random_phase(0, 46, 115);
      run_random_phase(12, 12, 115);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_PTR_DOWN;
      req_input_value = '0;
      rsp_stall       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      error_count     = 0;
      cycle_count     = 0;
      gap_pct         = 0;
      stall_pct       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_all_opcodes();
      test_pointer_bounds();
      test_zero_length();
      test_random_programs();

      drain();
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("tiny_pointer_isa_executor_tb OK");
      end else begin
         $display("tiny_pointer_isa_executor_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

### tiny_pointer_isa_executor.f
+incdir+hdl
hdl/tpie_pkg.sv
hdl/tpie_core.sv
hdl/tiny_pointer_isa_executor.sv
tb/tiny_pointer_isa_executor_tb.sv
